[rtl/pgp_pkg.sv]
// pgp_pkg: shared constants, codes and types of the phosphor goniometer plotter
// used by the channel interfaces, the divider and the top level
package pgp_pkg;

    // default geometry and history size
    localparam int RING_DEPTH_DEF    = 512;
    localparam int PLOT_RADIUS_DEF   = 170;
    localparam int CANVAS_WIDTH_DEF  = 800;
    localparam int CANVAS_HEIGHT_DEF = 480;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int SEQ_W    = 32;
    localparam int AGE_W    = 9;
    localparam int PX_W     = 10;
    localparam int PY_W     = 9;
    localparam int INT_W    = 8;
    localparam int HIST_W   = 10;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE  = 1'b1;

    // item opcodes and display modes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PLOT = 1'b1;
    localparam logic MODE_XY = 1'b0;
    localparam logic MODE_MS = 1'b1;

    // reset values and intensity scales
    localparam logic [HIST_W-1:0] HIST_RESET = 10'd256;
    localparam logic [SEQ_W-1:0]  SEQ_RESET  = 32'hFFFF_FFFF;
    localparam logic [INT_W-1:0]  GREEN_FULL = 8'd204;
    localparam logic [INT_W-1:0]  BLUE_FULL  = 8'd170;

    // samples are Q1.15
    localparam int Q_FRAC = 15;

    // shared multiplier: age cubed is 27 bits, depth up to 4096 keeps d squared at 24
    localparam int A3_W    = 3 * AGE_W;
    localparam int MUL_A_W = A3_W + 1;
    localparam int MUL_B_W = 13;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // divider: quotient never passes the full intensity
    localparam int QUOT_W = INT_W;
    localparam int NUM_W  = A3_W + INT_W;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/pgp_if.sv]
// pgp_if: valid/ready channels of the phosphor goniometer plotter
// depends on pgp_pkg for field widths
interface pgp_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [pgp_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [pgp_pkg::SAMPLE_W-1:0] right_sample;
    logic [pgp_pkg::SEQ_W-1:0]           sequence_req;
    logic [pgp_pkg::AGE_W-1:0]           age;

    modport source (output valid, opcode, left_sample, right_sample, sequence_req, age,
                    input ready);
    modport sink (input valid, opcode, left_sample, right_sample, sequence_req, age,
                  output ready);
endinterface

interface pgp_out_if;
    logic                        valid;
    logic                        ready;
    logic [pgp_pkg::PX_W-1:0]    pixel_x;
    logic [pgp_pkg::PY_W-1:0]    pixel_y;
    logic [pgp_pkg::INT_W-1:0]   green;
    logic [pgp_pkg::INT_W-1:0]   blue;
    logic                        last_pixel;

    modport source (output valid, pixel_x, pixel_y, green, blue, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, green, blue, last_pixel, output ready);
endinterface

[rtl/pgp_div.sv]
// pgp_div: restoring divider, one quotient bit per cycle
// depends on pgp_pkg for widths and the status struct
module pgp_div #(
    parameter int NUM_W = pgp_pkg::NUM_W,
    parameter int DEN_W = 3 * $clog2(pgp_pkg::RING_DEPTH_DEF),
    parameter int Q_W   = pgp_pkg::QUOT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    numer,
    input  logic [DEN_W-1:0]    denom,
    output pgp_pkg::div_stat_t  stat,
    output logic [Q_W-1:0]      quot
);

    localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int KW    = $clog2(Q_W);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CMP_W-1:0] shifted;
    logic [CMP_W-1:0] diff;
    logic             ge;

    assign shifted = CMP_W'(den_reg) << k_reg;
    assign ge      = CMP_W'(rem_reg) >= shifted;
    assign diff    = CMP_W'(rem_reg) - shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer;
            den_next  = denom;
            q_next    = '0;
            k_next    = KW'(Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = diff[NUM_W-1:0];
            end
            q_next = {q_reg[Q_W-2:0], ge};
            if (k_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

[rtl/phosphor_goniometer_plotter_top.sv]
// phosphor_goniometer_plotter_top: sample ring, brightness and blob sequencer
// depends on pgp_pkg, pgp_if and pgp_div
//
// in_ch takes push and plot items. A push stores a left/right pair in the ring
// (skipped when its sequence number repeats the last one). A plot names an age,
// 0 the oldest kept pair, and yields up to five pixel items on out_ch: the center
// at the intensity for its age, then left, right, up and down at half that; pixels
// off the canvas are dropped and last_pixel marks the final one sent. A plot with
// an empty history or an age not below the fill count sends nothing. Any other plot
// holds in_ch low until the sequencer is idle again, longer when out_ch stalls: the
// shared multiplier runs eight products, each in S_MUL and S_CAP (age cubed, d
// cubed, both scaled intensities, both coordinates), the bit-serial divider runs on
// each of green and blue (load, eight quotient bits, done), S_GEO places the blob,
// S_MASK tests it against the canvas, and S_EMIT steps the five pixel positions,
// skipped ones included. in_ch is ready only while the sequencer is idle. out_ch
// has one output register; a stall holds the emitter on the current pixel.
// Registers are written through cfg_we/cfg_index/cfg_data while the block is idle;
// the user must keep to that, the block itself does not enforce it. Reset empties
// the history, sets the limit to 256 and the mode to XY; the ring memory itself is
// not cleared, entries past the fill count are never read.
module phosphor_goniometer_plotter_top #(
    parameter int RING_DEPTH    = pgp_pkg::RING_DEPTH_DEF,
    parameter int PLOT_RADIUS   = pgp_pkg::PLOT_RADIUS_DEF,
    parameter int CANVAS_WIDTH  = pgp_pkg::CANVAS_WIDTH_DEF,
    parameter int CANVAS_HEIGHT = pgp_pkg::CANVAS_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pgp_in_if.sink                            in_ch,
    pgp_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [pgp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pgp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int DBW   = AW;
    localparam int D3_W  = 3 * DBW;
    localparam int LIM_W = (pgp_pkg::HIST_W > CNT_W) ? pgp_pkg::HIST_W : CNT_W;
    localparam int AC_W  = (pgp_pkg::AGE_W > CNT_W) ? pgp_pkg::AGE_W : CNT_W;
    localparam int IX_W  = ((AC_W > AW) ? AC_W : AW) + 2;
    localparam int CRD_W = 14;
    localparam int VW    = pgp_pkg::SAMPLE_W + 1;
    localparam int PAIR_W = 2 * pgp_pkg::SAMPLE_W;
    localparam int BLOB_N = 5;
    localparam int PIX_W  = $clog2(BLOB_N);
    localparam logic [PIX_W-1:0] PIX_CENTER = '0;
    localparam logic [PIX_W-1:0] PIX_LAST   = PIX_W'(BLOB_N - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CAP  = 4'd2;
    localparam logic [3:0] S_DG   = 4'd3;
    localparam logic [3:0] S_DGW  = 4'd4;
    localparam logic [3:0] S_DB   = 4'd5;
    localparam logic [3:0] S_DBW  = 4'd6;
    localparam logic [3:0] S_GEO  = 4'd7;
    localparam logic [3:0] S_MASK = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    // multiplier operations, in issue order
    localparam logic [2:0] M_AA  = 3'd0;
    localparam logic [2:0] M_A2A = 3'd1;
    localparam logic [2:0] M_DD  = 3'd2;
    localparam logic [2:0] M_D2D = 3'd3;
    localparam logic [2:0] M_GN  = 3'd4;
    localparam logic [2:0] M_BN  = 3'd5;
    localparam logic [2:0] M_X   = 3'd6;
    localparam logic [2:0] M_Y   = 3'd7;

    // ring memory
    logic [PAIR_W-1:0] mem [RING_DEPTH];
    logic [PAIR_W-1:0] rd_data_reg;

    // control state
    logic [3:0]                    state_reg, state_next;
    logic [2:0]                    op_reg, op_next;
    logic [PIX_W-1:0]              pix_reg, pix_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [pgp_pkg::SEQ_W-1:0]     seen_seq_reg, seen_seq_next;
    logic [pgp_pkg::HIST_W-1:0]    hist_reg, hist_next;
    logic                          mode_reg, mode_next;
    logic                          out_valid_reg, out_valid_next;

    // datapath
    logic [pgp_pkg::AGE_W-1:0]     age_reg;
    logic [DBW-1:0]                d_reg;
    logic [AW-1:0]                 idx_reg;
    logic signed [pgp_pkg::MUL_P_W-1:0] mul_reg;
    logic [2*pgp_pkg::AGE_W-1:0]   a2_reg;
    logic [pgp_pkg::A3_W-1:0]      a3_reg;
    logic [2*DBW-1:0]              d2_reg;
    logic [D3_W-1:0]               d3_reg;
    logic [pgp_pkg::NUM_W-1:0]     ng_reg, nb_reg;
    logic signed [CRD_W-1:0]       xo_reg, yo_reg, cx_reg, cy_reg;
    logic [pgp_pkg::INT_W-1:0]     g_reg, b_reg;
    logic [BLOB_N-1:0]             mask_reg;
    logic [pgp_pkg::PX_W-1:0]      out_x_reg;
    logic [pgp_pkg::PY_W-1:0]      out_y_reg;
    logic [pgp_pkg::INT_W-1:0]     out_g_reg, out_b_reg;
    logic                          out_last_reg;

    // combinational helpers
    logic                          accept_in, push_new, plot_in, plot_ok;
    logic [LIM_W-1:0]              hist_ext, lim_w;
    logic [CNT_W-1:0]              lim_c, cnt_inc, cnt_push;
    logic [DBW-1:0]                d_c;
    logic [IX_W-1:0]               idx_sum, idx_fix;
    logic signed [VW-1:0]          lv, rv, vx, vy;
    logic signed [pgp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pgp_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pgp_pkg::MUL_P_W-1:0] mul_c;
    logic [4:0]                    shift_amt;
    logic signed [pgp_pkg::MUL_P_W-1:0] mul_bias, mul_shift;
    logic signed [CRD_W-1:0]       trunc_c;
    logic signed [CRD_W-1:0]       kx [BLOB_N];
    logic signed [CRD_W-1:0]       ky [BLOB_N];
    logic [BLOB_N-1:0]             mask_c;
    logic [BLOB_N-1:0]             mask_hi;
    logic                          slot_free, emit;
    logic                          div_start;
    logic [pgp_pkg::NUM_W-1:0]     div_numer;
    pgp_pkg::div_stat_t            div_stat;
    logic [pgp_pkg::QUOT_W-1:0]    div_quot;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept_in   = in_ch.valid && in_ch.ready;
    assign push_new    = accept_in && (in_ch.opcode == pgp_pkg::OP_PUSH)
                         && (in_ch.sequence_req != seen_seq_reg);
    assign plot_in     = accept_in && (in_ch.opcode == pgp_pkg::OP_PLOT);
    assign plot_ok     = plot_in && (cnt_reg != '0)
                         && (AC_W'(in_ch.age) < AC_W'(cnt_reg));

    // history limit saturated to 1..depth
    assign hist_ext = LIM_W'(hist_reg);
    always_comb
    begin
        if (hist_reg == '0)
            lim_w = LIM_W'(1);
        else if (hist_ext > LIM_W'(RING_DEPTH))
            lim_w = LIM_W'(RING_DEPTH);
        else
            lim_w = hist_ext;
    end
    assign lim_c    = lim_w[CNT_W-1:0];
    assign cnt_inc  = (cnt_reg < CNT_W'(RING_DEPTH)) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_push = (cnt_inc > lim_c) ? lim_c : cnt_inc;

    assign d_c = (cnt_reg > CNT_W'(1)) ? DBW'(cnt_reg - 1'b1) : DBW'(1);

    // oldest kept pair sits fill count entries behind the write position
    assign idx_sum = IX_W'(wp_reg) + IX_W'(in_ch.age) - IX_W'(cnt_reg);
    assign idx_fix = idx_sum[IX_W-1] ? idx_sum + IX_W'(RING_DEPTH) : idx_sum;

    // pair read back and mapped for the current mode
    assign lv = VW'($signed(rd_data_reg[PAIR_W-1:pgp_pkg::SAMPLE_W]));
    assign rv = VW'($signed(rd_data_reg[pgp_pkg::SAMPLE_W-1:0]));
    assign vx = (mode_reg == pgp_pkg::MODE_MS) ? lv - rv : lv;
    assign vy = (mode_reg == pgp_pkg::MODE_MS) ? lv + rv : rv;

    // shared multiplier operand select
    always_comb
    begin
        case (op_reg)
            M_AA:
            begin
                mul_a = pgp_pkg::MUL_A_W'(age_reg);
                mul_b = pgp_pkg::MUL_B_W'(age_reg);
            end
            M_A2A:
            begin
                mul_a = pgp_pkg::MUL_A_W'(a2_reg);
                mul_b = pgp_pkg::MUL_B_W'(age_reg);
            end
            M_DD:
            begin
                mul_a = pgp_pkg::MUL_A_W'(d_reg);
                mul_b = pgp_pkg::MUL_B_W'(d_reg);
            end
            M_D2D:
            begin
                mul_a = pgp_pkg::MUL_A_W'(d2_reg);
                mul_b = pgp_pkg::MUL_B_W'(d_reg);
            end
            M_GN:
            begin
                mul_a = pgp_pkg::MUL_A_W'(a3_reg);
                mul_b = pgp_pkg::MUL_B_W'(pgp_pkg::GREEN_FULL);
            end
            M_BN:
            begin
                mul_a = pgp_pkg::MUL_A_W'(a3_reg);
                mul_b = pgp_pkg::MUL_B_W'(pgp_pkg::BLUE_FULL);
            end
            M_X:
            begin
                mul_a = pgp_pkg::MUL_A_W'(vx);
                mul_b = pgp_pkg::MUL_B_W'(PLOT_RADIUS);
            end
            M_Y:
            begin
                mul_a = pgp_pkg::MUL_A_W'(vy);
                mul_b = pgp_pkg::MUL_B_W'(PLOT_RADIUS);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_c = mul_a * mul_b;

    // scale back by 2^15 (XY) or 2^16 (mid/side), rounding toward zero
    assign shift_amt = (mode_reg == pgp_pkg::MODE_MS) ? 5'(pgp_pkg::Q_FRAC + 1)
                                                       : 5'(pgp_pkg::Q_FRAC);
    assign mul_bias  = mul_reg[pgp_pkg::MUL_P_W-1]
                       ? (pgp_pkg::MUL_P_W'(1) << shift_amt) - 1'b1 : '0;
    assign mul_shift = (mul_reg + mul_bias) >>> shift_amt;
    assign trunc_c   = mul_shift[CRD_W-1:0];

    // blob positions: center, left, right, up, down
    assign kx[0] = cx_reg;
    assign kx[1] = cx_reg - 1'b1;
    assign kx[2] = cx_reg + 1'b1;
    assign kx[3] = cx_reg;
    assign kx[4] = cx_reg;
    assign ky[0] = cy_reg;
    assign ky[1] = cy_reg;
    assign ky[2] = cy_reg;
    assign ky[3] = cy_reg - 1'b1;
    assign ky[4] = cy_reg + 1'b1;

    always_comb
    begin
        for (int k = 0; k < BLOB_N; k++)
        begin
            mask_c[k] = (kx[k] >= 0) && (kx[k] < CRD_W'(CANVAS_WIDTH))
                        && (ky[k] >= 0) && (ky[k] < CRD_W'(CANVAS_HEIGHT));
        end
    end

    assign mask_hi   = mask_reg >> pix_reg;
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign emit      = (state_reg == S_EMIT) && mask_reg[pix_reg] && slot_free;

    assign div_start = (state_reg == S_DG) || (state_reg == S_DB);
    assign div_numer = (state_reg == S_DB) ? nb_reg : ng_reg;

    pgp_div #(
        .NUM_W (pgp_pkg::NUM_W),
        .DEN_W (D3_W),
        .Q_W   (pgp_pkg::QUOT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (d3_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // sequencer and register file
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pix_next       = pix_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        seen_seq_next  = seen_seq_reg;
        hist_next      = hist_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        if (cfg_we)
        begin
            case (cfg_index)
                pgp_pkg::CFG_HISTORY_LIMIT: hist_next = cfg_data[pgp_pkg::HIST_W-1:0];
                pgp_pkg::CFG_DISPLAY_MODE:  mode_next = cfg_data[0];
                default:                    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (push_new)
                begin
                    seen_seq_next = in_ch.sequence_req;
                    wp_next       = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    cnt_next      = cnt_push;
                end
                if (plot_ok)
                begin
                    op_next    = M_AA;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (op_reg == M_Y)
                begin
                    state_next = S_DG;
                end
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DG:
            begin
                state_next = S_DGW;
            end
            S_DGW:
            begin
                if (div_stat.done)
                    state_next = S_DB;
            end
            S_DB:
            begin
                state_next = S_DBW;
            end
            S_DBW:
            begin
                if (div_stat.done)
                    state_next = S_GEO;
            end
            S_GEO:
            begin
                state_next = S_MASK;
            end
            S_MASK:
            begin
                pix_next   = PIX_CENTER;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit)
                    out_valid_next = 1'b1;
                if (emit || !mask_reg[pix_reg])
                begin
                    if (pix_reg == PIX_LAST)
                        state_next = S_IDLE;
                    else
                        pix_next = pix_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= M_AA;
            pix_reg       <= PIX_CENTER;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            seen_seq_reg  <= pgp_pkg::SEQ_RESET;
            hist_reg      <= pgp_pkg::HIST_RESET;
            mode_reg      <= pgp_pkg::MODE_XY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pix_reg       <= pix_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            seen_seq_reg  <= seen_seq_next;
            hist_reg      <= hist_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (push_new)
            mem[wp_reg] <= {in_ch.left_sample, in_ch.right_sample};
        rd_data_reg <= mem[idx_reg];
    end

    // datapath captures
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_c;
        if (plot_ok)
        begin
            age_reg <= in_ch.age;
            d_reg   <= d_c;
            idx_reg <= idx_fix[AW-1:0];
        end
        if (state_reg == S_CAP)
        begin
            case (op_reg)
                M_AA:    a2_reg <= mul_reg[2*pgp_pkg::AGE_W-1:0];
                M_A2A:   a3_reg <= mul_reg[pgp_pkg::A3_W-1:0];
                M_DD:    d2_reg <= mul_reg[2*DBW-1:0];
                M_D2D:   d3_reg <= mul_reg[D3_W-1:0];
                M_GN:    ng_reg <= mul_reg[pgp_pkg::NUM_W-1:0];
                M_BN:    nb_reg <= mul_reg[pgp_pkg::NUM_W-1:0];
                M_X:     xo_reg <= trunc_c;
                M_Y:     yo_reg <= trunc_c;
                default: ;
            endcase
        end
        if (state_reg == S_DGW && div_stat.done)
            g_reg <= div_quot;
        if (state_reg == S_DBW && div_stat.done)
            b_reg <= div_quot;
        if (state_reg == S_GEO)
        begin
            cx_reg <= CRD_W'(CANVAS_WIDTH / 2) + xo_reg;
            cy_reg <= CRD_W'(CANVAS_HEIGHT / 2) - yo_reg;
        end
        if (state_reg == S_MASK)
            mask_reg <= mask_c;
        if (emit)
        begin
            out_x_reg    <= kx[pix_reg][pgp_pkg::PX_W-1:0];
            out_y_reg    <= ky[pix_reg][pgp_pkg::PY_W-1:0];
            out_g_reg    <= (pix_reg == PIX_CENTER) ? g_reg : g_reg >> 1;
            out_b_reg    <= (pix_reg == PIX_CENTER) ? b_reg : b_reg >> 1;
            out_last_reg <= (mask_hi[BLOB_N-1:1] == '0);
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_x    = out_x_reg;
    assign out_ch.pixel_y    = out_y_reg;
    assign out_ch.green      = out_g_reg;
    assign out_ch.blue       = out_b_reg;
    assign out_ch.last_pixel = out_last_reg;

`ifndef NO_ASSERTIONS
    a_seq_kept: assert property (@(posedge clk) disable iff (!rst_n)
        push_new |=> seen_seq_reg == $past(in_ch.sequence_req))
        else $error("sequence number not recorded after a push");

    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        push_new |=> (cnt_reg != '0) && (cnt_reg <= CNT_W'(RING_DEPTH)))
        else $error("fill count out of range after a push");

    a_bad_plot_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (plot_in && !plot_ok) |=> state_reg == S_IDLE)
        else $error("plot outside the history started the sequencer");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted pixel lost from the output register");
`endif

endmodule

[tb/sv/pgp_blob_checker.sv]
`timescale 1ns / 100ps
// pgp_blob_checker: watches the item and pixel channels of the goniometer plotter,
// predicts every blob from its own copy of the ring and registers, and counts errors
// depends on pgp_pkg and pgp_if
module pgp_blob_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    pgp_in_if                              in_ch,
    pgp_out_if                             out_ch,
    input  logic                           cfg_we,
    input  logic [pgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pgp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending_pixels,
    output int                             pixels_checked,
    output int                             kept_pairs
);

    localparam int RING   = pgp_pkg::RING_DEPTH_DEF;
    localparam int RADIUS = pgp_pkg::PLOT_RADIUS_DEF;
    localparam int WIDTH  = pgp_pkg::CANVAS_WIDTH_DEF;
    localparam int HEIGHT = pgp_pkg::CANVAS_HEIGHT_DEF;

    typedef struct packed {
        logic [pgp_pkg::PX_W-1:0]  x;
        logic [pgp_pkg::PY_W-1:0]  y;
        logic [pgp_pkg::INT_W-1:0] green;
        logic [pgp_pkg::INT_W-1:0] blue;
        logic                      last;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic signed [pgp_pkg::SAMPLE_W-1:0] left_ring  [RING];
    logic signed [pgp_pkg::SAMPLE_W-1:0] right_ring [RING];
    logic [pgp_pkg::AGE_W-1:0]           head;
    logic [pgp_pkg::HIST_W-1:0]          fill;
    logic [pgp_pkg::SEQ_W-1:0]           prev_seq;
    logic [pgp_pkg::HIST_W-1:0]          limit_reg;
    logic                                mode_reg;

    function automatic void store_pair(logic signed [pgp_pkg::SAMPLE_W-1:0] l,
                                       logic signed [pgp_pkg::SAMPLE_W-1:0] r,
                                       logic [pgp_pkg::SEQ_W-1:0] seq);
        int lim;
        if (seq == prev_seq)
            return;
        prev_seq = seq;
        left_ring[head] = l;
        right_ring[head] = r;
        head = head + 1'b1;
        if (fill < RING)
            fill = fill + 1'b1;
        // zero behaves as one, anything past the ring as the ring
        lim = (limit_reg == 0) ? 1 : ((limit_reg > RING) ? RING : int'(limit_reg));
        if (fill > lim)
            fill = pgp_pkg::HIST_W'(lim);
    endfunction

    function automatic void predict_blob(logic [pgp_pkg::AGE_W-1:0] age);
        longint cnt, d, a3, d3, lv, rv, xo, yo, cx, cy, px, py;
        int idx;
        logic [pgp_pkg::INT_W-1:0] g, b;
        int dx[5] = '{0, -1, 1, 0, 0};
        int dy[5] = '{0, 0, 0, -1, 1};
        pixel_t pix;
        pixel_t blob[$];
        cnt = fill;
        if (cnt == 0 || age >= cnt)
            return;
        d = (cnt > 1) ? cnt - 1 : 1;
        a3 = longint'(age) * age * age;
        d3 = d * d * d;
        g = pgp_pkg::INT_W'((longint'(pgp_pkg::GREEN_FULL) * a3) / d3);
        b = pgp_pkg::INT_W'((longint'(pgp_pkg::BLUE_FULL) * a3) / d3);
        idx = int'((longint'(head) + 2 * RING - cnt + age) % RING);
        lv = left_ring[idx];
        rv = right_ring[idx];
        // signed division truncates toward zero
        if (mode_reg == pgp_pkg::MODE_XY)
        begin
            xo = (lv * RADIUS) / 32768;
            yo = (rv * RADIUS) / 32768;
        end
        else
        begin
            xo = ((lv - rv) * RADIUS) / 65536;
            yo = ((lv + rv) * RADIUS) / 65536;
        end
        cx = WIDTH / 2 + xo;
        cy = HEIGHT / 2 - yo;
        // center, left, right, up, down; neighbors at half intensity
        for (int i = 0; i < 5; i++)
        begin
            px = cx + dx[i];
            py = cy + dy[i];
            if (px >= 0 && px < WIDTH && py >= 0 && py < HEIGHT)
            begin
                pix.x = pgp_pkg::PX_W'(px);
                pix.y = pgp_pkg::PY_W'(py);
                pix.green = (i == 0) ? g : (g >> 1);
                pix.blue = (i == 0) ? b : (b >> 1);
                pix.last = 1'b0;
                blob.push_back(pix);
            end
        end
        if (blob.size() > 0)
            blob[blob.size() - 1].last = 1'b1;
        foreach (blob[i])
            expected_pixels.push_back(blob[i]);
    endfunction

    function automatic void check_pixel(pixel_t got);
        pixel_t want;
        pixels_checked++;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel (%0d,%0d) g=%0d b=%0d last=%0b",
                         got.x, got.y, got.green, got.blue, got.last);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.green !== want.green ||
            got.blue !== want.blue || got.last !== want.last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("pixel %0d: expected (%0d,%0d) g=%0d b=%0d last=%0b",
                         pixels_checked, want.x, want.y, want.green, want.blue, want.last);
                $display("    got (%0d,%0d) g=%0d b=%0d last=%0b",
                         got.x, got.y, got.green, got.blue, got.last);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING; i++)
            begin
                left_ring[i] = '0;
                right_ring[i] = '0;
            end
            head = '0;
            fill = '0;
            prev_seq = pgp_pkg::SEQ_RESET;
            limit_reg = pgp_pkg::HIST_RESET;
            mode_reg = pgp_pkg::MODE_XY;
            expected_pixels.delete();
            mismatches = 0;
            pixels_checked = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_pixel({out_ch.pixel_x, out_ch.pixel_y, out_ch.green, out_ch.blue,
                             out_ch.last_pixel});
            if (cfg_we)
            begin
                case (cfg_index)
                    pgp_pkg::CFG_HISTORY_LIMIT: limit_reg = cfg_data[pgp_pkg::HIST_W-1:0];
                    pgp_pkg::CFG_DISPLAY_MODE:  mode_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.opcode == pgp_pkg::OP_PUSH)
                    store_pair(in_ch.left_sample, in_ch.right_sample, in_ch.sequence_req);
                else
                    predict_blob(in_ch.age);
            end
        end
        pending_pixels = expected_pixels.size();
        kept_pairs = fill;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: drives push/plot items and register writes into the goniometer plotter,
// stalls the pixel side at random and reports the verdict from pgp_blob_checker
// depends on pgp_pkg, pgp_if, pgp_blob_checker and phosphor_goniometer_plotter_top
module tb_top;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 64;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 400;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pgp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pgp_pkg::CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending_pixels;
    int pixels_checked;
    int kept_pairs;
    int pushes_sent;
    int plots_sent;
    bit no_gaps;
    logic [pgp_pkg::SEQ_W-1:0] recent_seq;

    pgp_in_if  in_ch();
    pgp_out_if out_ch();

    phosphor_goniometer_plotter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pgp_blob_checker u_blob_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending_pixels (pending_pixels),
        .pixels_checked (pixels_checked),
        .kept_pairs     (kept_pairs)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic offer_item(input logic op,
                              input logic signed [pgp_pkg::SAMPLE_W-1:0] l,
                              input logic signed [pgp_pkg::SAMPLE_W-1:0] r,
                              input logic [pgp_pkg::SEQ_W-1:0] seq,
                              input logic [pgp_pkg::AGE_W-1:0] a);
        while (!no_gaps && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.left_sample <= l;
        in_ch.right_sample <= r;
        in_ch.sequence_req <= seq;
        in_ch.age <= a;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (op == pgp_pkg::OP_PUSH)
            pushes_sent++;
        else
            plots_sent++;
    endtask

    task automatic push_pair(input logic signed [pgp_pkg::SAMPLE_W-1:0] l,
                             input logic signed [pgp_pkg::SAMPLE_W-1:0] r,
                             input logic [pgp_pkg::SEQ_W-1:0] seq);
        offer_item(pgp_pkg::OP_PUSH, l, r, seq, pgp_pkg::AGE_W'($urandom_range(511)));
        recent_seq = seq;
    endtask

    task automatic plot_at(input logic [pgp_pkg::AGE_W-1:0] a);
        offer_item(pgp_pkg::OP_PLOT, pgp_pkg::SAMPLE_W'($urandom),
                   pgp_pkg::SAMPLE_W'($urandom), $urandom, a);
    endtask

    function automatic logic signed [pgp_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return '1;
            4: return pgp_pkg::SAMPLE_W'($urandom_range(200)) - 16'sd100;
            default: return pgp_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [pgp_pkg::SEQ_W-1:0] pick_seq();
        int k;
        k = $urandom_range(99);
        if (k < 6)
            return recent_seq;
        if (k < 8)
            return pgp_pkg::SEQ_RESET;
        return $urandom;
    endfunction

    function automatic logic [pgp_pkg::AGE_W-1:0] pick_age();
        int k;
        k = $urandom_range(99);
        if (kept_pairs == 0 || k < 12)
            return pgp_pkg::AGE_W'($urandom_range(511));
        if (k < 15 && kept_pairs < 512)
            return pgp_pkg::AGE_W'(kept_pairs);
        if (k < 22)
            return pgp_pkg::AGE_W'(kept_pairs - 1);
        if (k < 27)
            return '0;
        return pgp_pkg::AGE_W'($urandom_range(kept_pairs - 1));
    endfunction

    task automatic push_random();
        push_pair(pick_sample(), pick_sample(), pick_seq());
    endtask

    task automatic run_mix(input int n, input int push_pct);
        repeat (n)
        begin
            if ($urandom_range(99) < push_pct)
                push_random();
            else
                plot_at(pick_age());
        end
    endtask

    // let every pixel drain, then give a plot with no pixels time to finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_pixels != 0)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [pgp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pgp_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic begin_phase(input logic [pgp_pkg::HIST_W-1:0] hist, input logic mode);
        drain();
        write_reg(pgp_pkg::CFG_HISTORY_LIMIT, hist);
        // upper bits of the mode write are don't-care
        write_reg(pgp_pkg::CFG_DISPLAY_MODE, {9'($urandom_range(511)), mode});
    endtask

    // pixel side: random stalls plus one long hold-off once traffic is flowing
    initial
    begin : pixel_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && pixels_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= no_gaps || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("** phosphor_goniometer_plotter_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = pgp_pkg::OP_PUSH;
        in_ch.left_sample = '0;
        in_ch.right_sample = '0;
        in_ch.sequence_req = '0;
        in_ch.age = '0;
        pushes_sent = 0;
        plots_sent = 0;
        no_gaps = 1'b0;
        recent_seq = pgp_pkg::SEQ_RESET;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty history, repeated sequence numbers, extreme samples, fade ends
        plot_at(9'd0);
        push_pair(16'sh7FFF, 16'sh8000, pgp_pkg::SEQ_RESET);  // matches the reset sequence
        plot_at(9'd0);
        push_pair(16'sh7FFF, 16'sh8000, 32'd0);
        plot_at(9'd0);                                  // single pair fades to zero
        push_pair(16'sh0000, 16'sh0000, 32'd0);         // repeat, ignored
        plot_at(9'd0);
        plot_at(9'd1);                                  // past the fill count
        push_pair(16'sh8000, 16'sh7FFF, 32'd1);
        push_pair(-16'sd1, 16'sd1, pgp_pkg::SEQ_RESET);
        push_pair(16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFE);
        plot_at(9'd4);
        plot_at(9'd3);                                  // newest at full intensity
        plot_at(9'd2);
        plot_at(9'd1);
        plot_at(9'd511);
        begin_phase(pgp_pkg::HIST_RESET, pgp_pkg::MODE_MS);
        plot_at(9'd0);
        plot_at(9'd1);
        plot_at(9'd2);
        plot_at(9'd3);

        // deep history, limit past the ring depth
        begin_phase(10'd1023, pgp_pkg::MODE_XY);
        repeat (150)
            push_random();
        run_mix(60, 30);

        // no idling on either side for this stretch
        drain();
        no_gaps = 1'b1;
        begin_phase(10'd512, pgp_pkg::MODE_MS);
        run_mix(50, 30);
        drain();
        no_gaps = 1'b0;

        begin_phase(10'd96, pgp_pkg::MODE_XY);
        run_mix(40, 40);
        begin_phase(10'd1, pgp_pkg::MODE_MS);
        run_mix(30, 50);
        begin_phase(10'd0, pgp_pkg::MODE_XY);
        run_mix(25, 50);
        begin_phase(10'd300, pgp_pkg::MODE_MS);
        run_mix(40, 60);
        begin_phase(10'd2, pgp_pkg::MODE_XY);
        run_mix(20, 50);

        drain();
        $display("covered %0d push and %0d plot items, %0d pixels checked", pushes_sent,
                 plots_sent, pixels_checked);
        $display("history limits 0 to 1023 in XY and mid/side, repeated sequence numbers,");
        $display("shrinking history and one long pixel stall");
        if (mismatches == 0 && pending_pixels == 0)
            $display("** phosphor_goniometer_plotter_top: PASSED **");
        else
            $display("** phosphor_goniometer_plotter_top: FAILED **");
        $finish;
    end

endmodule

[sim.f]
rtl/pgp_pkg.sv
rtl/pgp_if.sv
rtl/pgp_div.sv
rtl/phosphor_goniometer_plotter_top.sv
tb/sv/pgp_blob_checker.sv
tb/sv/tb_top.sv
